// File: hdl/csrmv_pkg.sv
// shared types and constants for the csr sparse matrix-vector engine
// no dependencies
`default_nettype none

package csrmv_pkg;

	localparam int DATA_W  = 32;
	localparam int COL_W   = 10;
	localparam int ROW_W   = 16;
	localparam int SHIFT_W = 5;
	localparam int ACC_W   = 48;
	localparam int PROD_W  = 2 * DATA_W;

	localparam int VECTOR_DEPTH_DEF = 1024;

	localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(16);

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_MAC     = 2'd1,
		OP_MAC_END = 2'd2,
		OP_END     = 2'd3
	} opcode_t;

	// per-item control carried down the pipeline
	typedef struct packed {
		logic mac;
		logic row_end;
	} item_ctl_t;

endpackage

`default_nettype wire

// File: hdl/csr_sparse_matvec_engine.sv
// csr sparse matrix-vector engine top level: x store, multiplier, row accumulator
// depends on csrmv_pkg
`default_nettype none

// Streams CSR items and produces one row sum per row end. Load items write x into a
// single-port synchronous store of VECTOR_DEPTH words; nonzero items read x at their
// column, multiply (Q16.16), shift right by product_shift and add into a saturating
// 48-bit accumulator. It takes one item per clock unless the output stalls it: the x
// store does one read or one write per cycle, the 32x32 multiply and the accumulate
// are each a single stage. Load items finish in the cycle they are accepted. No
// clearing pass runs after reset; x entries read before being loaded give undefined
// sums. The user must write product_shift only while idle; it is not enforced.
module csr_sparse_matvec_engine #(
	parameter int VECTOR_DEPTH = csrmv_pkg::VECTOR_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// item input channel
	input  wire logic                             in_valid,
	output      logic                             in_stall,
	input  wire logic [1:0]                       opcode,
	input  wire logic [csrmv_pkg::COL_W-1:0]      column_index,
	input  wire logic signed [csrmv_pkg::DATA_W-1:0] operand,
	// result channel
	output      logic                             out_valid,
	input  wire logic                             out_stall,
	output      logic [csrmv_pkg::ROW_W-1:0]      row_number,
	output      logic signed [csrmv_pkg::DATA_W-1:0] row_sum,
	// configuration write channel
	input  wire logic                             cfg_valid,
	output      logic                             cfg_ready,
	input  wire logic [csrmv_pkg::SHIFT_W-1:0]    product_shift
);

	localparam int AW     = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
	localparam int CW     = csrmv_pkg::COL_W;
	localparam int DW     = csrmv_pkg::DATA_W;
	localparam int PW     = csrmv_pkg::PROD_W;
	localparam int AccW   = csrmv_pkg::ACC_W;

	localparam logic signed [PW-1:0] ACC_MAX = PW'((64'sd1 <<< (AccW - 1)) - 64'sd1);
	localparam logic signed [PW-1:0] ACC_MIN = -ACC_MAX - PW'(1);
	localparam logic signed [PW-1:0] OUT_MAX = PW'((64'sd1 <<< (DW - 1)) - 64'sd1);
	localparam logic signed [PW-1:0] OUT_MIN = -OUT_MAX - PW'(1);

	// configuration
	logic [csrmv_pkg::SHIFT_W-1:0] shift_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= csrmv_pkg::SHIFT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			shift_q <= product_shift;
		end
	end

	// input decode
	csrmv_pkg::opcode_t    op;
	csrmv_pkg::item_ctl_t  in_ctl;
	logic [31:0]           col_wide;
	logic [AW+CW-1:0]      col_ext;
	logic [AW-1:0]         addr;
	logic                  in_range;
	logic                  in_fire;

	assign op       = csrmv_pkg::opcode_t'(opcode);
	assign col_wide = 32'(column_index);
	assign col_ext  = {{AW{1'b0}}, column_index};
	assign addr     = col_ext[AW-1:0];
	assign in_range = col_wide < 32'(VECTOR_DEPTH);

	always_comb begin
		unique case (op)
			csrmv_pkg::OP_LOAD:    in_ctl = '{mac: 1'b0, row_end: 1'b0};
			csrmv_pkg::OP_MAC:     in_ctl = '{mac: 1'b1, row_end: 1'b0};
			csrmv_pkg::OP_MAC_END: in_ctl = '{mac: 1'b1, row_end: 1'b1};
			csrmv_pkg::OP_END:     in_ctl = '{mac: 1'b0, row_end: 1'b1};
			default:               in_ctl = '{mac: 1'b0, row_end: 1'b0};
		endcase
	end

	// pipeline control
	logic                  valid_s1, valid_s2, valid_s3;
	csrmv_pkg::item_ctl_t  ctl_s1, ctl_s2, ctl_s3;
	logic                  rdy1, rdy2, rdy3, adv3;
	logic                  out_valid_q;
	logic                  out_load;

	// a row end can only retire when the output register is free or draining
	assign adv3     = valid_s3 && (!ctl_s3.row_end || !out_valid_q || !out_stall);
	assign rdy3     = !valid_s3 || adv3;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_stall = !rdy1;
	assign in_fire  = in_valid && !in_stall;
	assign out_load = adv3 && ctl_s3.row_end;

	// x store: one access per cycle, registered read
	logic [DW-1:0]         mem [VECTOR_DEPTH];
	logic [DW-1:0]         rd_s1;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (op == csrmv_pkg::OP_LOAD) begin
				if (in_range) mem[addr] <= operand;
			end else begin
				rd_s1 <= mem[addr];
			end
		end
	end

	// stage 1: x read, operand held
	logic signed [DW-1:0]  val_s1;
	logic                  range_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy1) begin
			valid_s1 <= in_fire && (op != csrmv_pkg::OP_LOAD);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			val_s1   <= operand;
			range_s1 <= in_range;
			ctl_s1   <= in_ctl;
		end
	end

	// stage 2: product
	logic signed [DW-1:0]  x_s1;
	logic signed [PW-1:0]  prod_s2;

	assign x_s1 = range_s1 ? $signed(rd_s1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && rdy2) begin
			prod_s2 <= ctl_s1.mac ? PW'(val_s1) * PW'(x_s1) : '0;
			ctl_s2  <= ctl_s1;
		end
	end

	// stage 3: arithmetic shift, floor rounding
	logic signed [PW-1:0]  term_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && rdy3) begin
			term_s3 <= prod_s2 >>> shift_q;
			ctl_s3  <= ctl_s2;
		end
	end

	// accumulate and retire
	logic signed [AccW-1:0] acc_q;
	logic signed [PW-1:0]   sum;
	logic signed [AccW-1:0] acc_sat;
	logic signed [DW-1:0]   out_sat;
	logic [csrmv_pkg::ROW_W-1:0] row_cnt_q;
	logic signed [DW-1:0]   row_sum_q;
	logic [csrmv_pkg::ROW_W-1:0] row_number_q;

	assign sum = PW'(acc_q) + term_s3;

	always_comb begin
		priority if (sum > ACC_MAX) acc_sat = ACC_MAX[AccW-1:0];
		else if (sum < ACC_MIN)     acc_sat = ACC_MIN[AccW-1:0];
		else                        acc_sat = sum[AccW-1:0];
		// clamping to 32 bits directly matches clamping the 48-bit value first
		priority if (sum > OUT_MAX) out_sat = OUT_MAX[DW-1:0];
		else if (sum < OUT_MIN)     out_sat = OUT_MIN[DW-1:0];
		else                        out_sat = sum[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			row_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv3) begin
				acc_q <= ctl_s3.row_end ? '0 : acc_sat;
			end
			if (out_load) begin
				row_cnt_q   <= row_cnt_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			row_sum_q    <= out_sat;
			row_number_q <= row_cnt_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign row_sum    = row_sum_q;
	assign row_number = row_number_q;

	// checks
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !out_load)
		else $error("output register overwritten while stalled");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 && !valid_s2 && !valid_s3 |-> !in_stall)
		else $error("input stalled with empty pipeline");

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> acc_q == '0)
		else $error("accumulator not cleared after row end");

	a_row_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> row_cnt_q == $past(row_cnt_q) + 1'b1)
		else $error("row counter did not advance on row end");

endmodule

`default_nettype wire

// File: tb/sv/tb_csr_sparse_matvec_engine.sv
// self-checking testbench for csr_sparse_matvec_engine: directed and random CSR item
// streams, checked against an in-bench row-sum predictor with random idling on both sides
// depends on csrmv_pkg and the csr_sparse_matvec_engine rtl
`timescale 1ns / 1ps

module tb_csr_sparse_matvec_engine;

	localparam int VEC_DEPTH      = csrmv_pkg::VECTOR_DEPTH_DEF;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int QUIET_CYCLES   = 12;
	localparam int DRAIN_CYCLES   = 20;
	localparam int RX_HOLD_CYCLES = 200;
	localparam int MAX_REPORTS    = 10;

	localparam logic signed [63:0] ACC_HI = 64'sh0000_7fff_ffff_ffff;
	localparam logic signed [63:0] ACC_LO = -ACC_HI - 64'sd1;
	localparam logic signed [63:0] SUM_HI = 64'sh0000_0000_7fff_ffff;
	localparam logic signed [63:0] SUM_LO = -SUM_HI - 64'sd1;

	typedef struct {
		logic [csrmv_pkg::ROW_W-1:0]  row;
		logic [csrmv_pkg::DATA_W-1:0] sum;
	} row_sum_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] opcode;
	logic [csrmv_pkg::COL_W-1:0] column_index;
	logic signed [csrmv_pkg::DATA_W-1:0] operand;
	logic out_valid;
	logic out_stall;
	logic [csrmv_pkg::ROW_W-1:0] row_number;
	logic signed [csrmv_pkg::DATA_W-1:0] row_sum;
	logic cfg_valid;
	logic cfg_ready;
	logic [csrmv_pkg::SHIFT_W-1:0] product_shift;

	// predictor state
	logic signed [csrmv_pkg::DATA_W-1:0] x_val [VEC_DEPTH];
	bit x_set [VEC_DEPTH];
	int loaded_cols[$];
	logic signed [csrmv_pkg::ACC_W-1:0] row_acc;
	logic [csrmv_pkg::ROW_W-1:0] row_ctr;
	logic [csrmv_pkg::SHIFT_W-1:0] shift_cfg;
	row_sum_t pending_row_sums[$];

	int fail_count;
	int items_sent;
	int cycle_count;
	bit idle_on;
	bit rx_hold;
	int rx_burst;
	event rx_hold_go;

	csr_sparse_matvec_engine DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.column_index (column_index),
		.operand      (operand),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.row_number   (row_number),
		.row_sum      (row_sum),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.product_shift(product_shift)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL csr_sparse_matvec_engine");
			$finish;
		end
	end

	function automatic void log_error(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%s", msg);
	endfunction

	// updates x store, accumulator and row counter for one accepted item
	function automatic void accumulate_item(input csrmv_pkg::opcode_t op,
			input logic [csrmv_pkg::COL_W-1:0] col,
			input logic signed [csrmv_pkg::DATA_W-1:0] val);
		logic signed [63:0] xv;
		logic signed [63:0] mv;
		logic signed [63:0] prod;
		logic signed [63:0] total;
		row_sum_t res;
		if (op == csrmv_pkg::OP_LOAD) begin
			if (col < VEC_DEPTH) begin
				if (!x_set[col])
					loaded_cols.push_back(col);
				x_set[col] = 1'b1;
				x_val[col] = val;
			end
			return;
		end
		if (op == csrmv_pkg::OP_MAC || op == csrmv_pkg::OP_MAC_END) begin
			xv = (col < VEC_DEPTH) ? x_val[col] : 64'sd0;
			mv = val;
			prod = (mv * xv) >>> shift_cfg;
			total = row_acc;
			total = total + prod;
			if (total > ACC_HI)
				total = ACC_HI;
			else if (total < ACC_LO)
				total = ACC_LO;
			row_acc = total[csrmv_pkg::ACC_W-1:0];
		end
		if (op == csrmv_pkg::OP_MAC_END || op == csrmv_pkg::OP_END) begin
			total = row_acc;
			if (total > SUM_HI)
				total = SUM_HI;
			else if (total < SUM_LO)
				total = SUM_LO;
			res.row = row_ctr;
			res.sum = total[csrmv_pkg::DATA_W-1:0];
			pending_row_sums.push_back(res);
			row_acc = '0;
			row_ctr = row_ctr + 1'b1;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		row_sum_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_row_sums.size() == 0) begin
				log_error($sformatf("unexpected result: row %0d sum %h", row_number, row_sum));
			end else begin
				exp_res = pending_row_sums.pop_front();
				if (row_number !== exp_res.row)
					log_error($sformatf("row_number mismatch: expected %0d got %0d",
						exp_res.row, row_number));
				if (row_sum !== exp_res.sum)
					log_error($sformatf("row_sum mismatch on row %0d: expected %h got %h",
						exp_res.row, exp_res.sum, row_sum));
			end
		end
	end

	// receiver stall: random bursts plus the long hold
	initial begin
		out_stall = 1'b0;
		rx_burst = 0;
		forever begin
			@(negedge clk);
			if (rx_burst > 0)
				rx_burst--;
			else if (idle_on && $urandom_range(0, 7) == 0)
				rx_burst = $urandom_range(1, 14);
			out_stall = rx_hold || (rx_burst > 0);
		end
	end

	initial begin
		rx_hold = 1'b0;
		forever begin
			@(rx_hold_go);
			@(posedge clk);
			rx_hold = 1'b1;
			repeat (RX_HOLD_CYCLES) @(posedge clk);
			rx_hold = 1'b0;
		end
	end

	task automatic send_item(input csrmv_pkg::opcode_t op,
			input logic [csrmv_pkg::COL_W-1:0] col,
			input logic signed [csrmv_pkg::DATA_W-1:0] val);
		int gap;
		gap = (idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		column_index = col;
		operand = val;
		do @(posedge clk); while (in_stall);
		accumulate_item(op, col, val);
		items_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain_results();
		while (pending_row_sums.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_product_shift(input logic [csrmv_pkg::SHIFT_W-1:0] s);
		drain_results();
		// mac items leave no result, so give the pipeline time to empty
		repeat (QUIET_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		product_shift = s;
		do @(posedge clk); while (!cfg_ready);
		shift_cfg = s;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic signed [csrmv_pkg::DATA_W-1:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return '0;
			3, 4, 5: return int'($urandom_range(0, 32'h7_ffff)) - 32'sh4_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [csrmv_pkg::COL_W-1:0] rand_col();
		return csrmv_pkg::COL_W'($urandom_range(0, VEC_DEPTH - 1));
	endfunction

	function automatic logic [csrmv_pkg::COL_W-1:0] pick_loaded_col();
		return csrmv_pkg::COL_W'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
	endfunction

	// one CSR row, with the odd x reload mixed in
	task automatic send_row(input int nnz);
		int k;
		bit close_on_mac;
		close_on_mac = (nnz > 0) && ($urandom_range(0, 1) == 1);
		for (k = 0; k < nnz; k++) begin
			if ($urandom_range(0, 5) == 0)
				send_item(csrmv_pkg::OP_LOAD, rand_col(), rand_operand());
			send_item((close_on_mac && k == nnz - 1) ? csrmv_pkg::OP_MAC_END
				: csrmv_pkg::OP_MAC, pick_loaded_col(), rand_operand());
		end
		if (!close_on_mac)
			send_item(csrmv_pkg::OP_END, rand_col(), $urandom());
	endtask

	task automatic test_directed();
		send_item(csrmv_pkg::OP_LOAD, 10'd0, 32'h7fff_ffff);
		send_item(csrmv_pkg::OP_LOAD, 10'd1023, 32'h8000_0000);
		send_item(csrmv_pkg::OP_LOAD, 10'd1, 32'hffff_ffff);
		send_item(csrmv_pkg::OP_LOAD, 10'd2, 32'h0001_0000);
		send_item(csrmv_pkg::OP_LOAD, 10'd3, 32'h0001_8000);
		// 2.0 * 1.0 + -1.0 * 1.5 at the reset shift
		send_item(csrmv_pkg::OP_MAC, 10'd2, 32'h0002_0000);
		send_item(csrmv_pkg::OP_MAC_END, 10'd3, 32'hffff_0000);
		// empty row, operand ignored
		send_item(csrmv_pkg::OP_END, 10'd5, 32'hdead_beef);
		// tiny negative product floors to -1
		send_item(csrmv_pkg::OP_MAC, 10'd1, 32'h0000_0001);
		send_item(csrmv_pkg::OP_END, 10'd1023, 32'h0);
		send_item(csrmv_pkg::OP_MAC_END, 10'd0, 32'h7fff_ffff);
		write_product_shift(5'd0);
		// accumulator pinned high, then low
		send_item(csrmv_pkg::OP_MAC, 10'd1023, 32'h8000_0000);
		send_item(csrmv_pkg::OP_MAC, 10'd0, 32'h7fff_ffff);
		send_item(csrmv_pkg::OP_END, 10'd0, 32'hffff_ffff);
		send_item(csrmv_pkg::OP_MAC, 10'd0, 32'h8000_0000);
		send_item(csrmv_pkg::OP_MAC_END, 10'd1, 32'h0000_0001);
		write_product_shift(5'd31);
		send_item(csrmv_pkg::OP_MAC_END, 10'd0, 32'h7fff_ffff);
		send_item(csrmv_pkg::OP_MAC, 10'd1023, 32'h8000_0000);
		send_item(csrmv_pkg::OP_MAC_END, 10'd1, 32'h8000_0000);
		write_product_shift(csrmv_pkg::SHIFT_RESET);
	endtask

	task automatic test_random_rows();
		int p;
		int goal;
		logic [csrmv_pkg::SHIFT_W-1:0] s;
		repeat (48)
			send_item(csrmv_pkg::OP_LOAD, rand_col(), rand_operand());
		for (p = 0; p < 4; p++) begin
			case (p)
				0: s = 5'd16;
				1: s = csrmv_pkg::SHIFT_W'($urandom_range(1, 30));
				2: s = 5'd0;
				default: s = 5'd31;
			endcase
			write_product_shift(s);
			goal = items_sent + 120;
			while (items_sent < goal)
				send_row($urandom_range(0, 6));
		end
		write_product_shift(csrmv_pkg::SHIFT_RESET);
	endtask

	task automatic test_output_backpressure();
		-> rx_hold_go;
		repeat (25)
			send_row($urandom_range(0, 2));
		drain_results();
	endtask

	task automatic test_sender_pause();
		repeat (10)
			send_row($urandom_range(0, 4));
		drain_results();
		repeat (10)
			send_row($urandom_range(0, 4));
	endtask

	task automatic test_row_end_stream();
		int k;
		// a run of row ends, mostly empty rows
		for (k = 0; k < 50; k++) begin
			if ($urandom_range(0, 7) == 0)
				send_item(csrmv_pkg::OP_MAC_END, pick_loaded_col(), rand_operand());
			else
				send_item(csrmv_pkg::OP_END, rand_col(), $urandom());
		end
	endtask

	task automatic test_full_rate();
		int goal;
		idle_on = 1'b0;
		goal = items_sent + 150;
		while (items_sent < goal)
			send_row($urandom_range(0, 6));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = csrmv_pkg::OP_LOAD;
		column_index = '0;
		operand = '0;
		cfg_valid = 1'b0;
		product_shift = csrmv_pkg::SHIFT_RESET;
		fail_count = 0;
		items_sent = 0;
		cycle_count = 0;
		idle_on = 1'b1;
		row_acc = '0;
		row_ctr = '0;
		shift_cfg = csrmv_pkg::SHIFT_RESET;
		for (int i = 0; i < VEC_DEPTH; i++) begin
			x_val[i] = '0;
			x_set[i] = 1'b0;
		end
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_rows();
		test_output_backpressure();
		test_sender_pause();
		test_row_end_stream();
		test_full_rate();

		in_valid = 1'b0;
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS csr_sparse_matvec_engine");
		else
			$display("FAIL csr_sparse_matvec_engine");
		$finish;
	end

endmodule

// File: files.f
hdl/csrmv_pkg.sv
hdl/csr_sparse_matvec_engine.sv
tb/sv/tb_csr_sparse_matvec_engine.sv
